// File: design/lmlt_pkg.sv
`timescale 1ns / 1ps

package lmlt_pkg;

   typedef logic [47:0] mac_type;
   typedef logic [15:0] count_type;
   typedef logic        func_type;

   localparam func_type  FUNC_LEARN  = 1'b0;
   localparam func_type  FUNC_LOOKUP = 1'b1;

   localparam count_type COUNT_MAX   = 16'hffff;
   localparam count_type COUNT_FIRST = 16'h0001;

   typedef struct packed {
      logic hit;
      logic saturated;
   } match_status_type;

endpackage

// File: design/lmlt_req_if.sv
`timescale 1ns / 1ps

interface lmlt_req_if;
   import lmlt_pkg::*;

   logic     valid;
   logic     ready;
   func_type func;
   mac_type  mac;

   modport source (output valid, output func, output mac, input ready);
   modport sink (input valid, input func, input mac, output ready);
endinterface

// File: design/lmlt_rsp_if.sv
`timescale 1ns / 1ps

interface lmlt_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, output hit, input ready);
   modport sink (input valid, input hit, output ready);
endinterface

// File: design/lmlt_match.sv
`timescale 1ns / 1ps

module lmlt_match #(
   parameter int TABLE_ENTRIES = 8
) (
   input  lmlt_pkg::mac_type          mac,
   input  lmlt_pkg::mac_type          addrs [TABLE_ENTRIES],
   input  lmlt_pkg::count_type        counts [TABLE_ENTRIES],
   output logic [TABLE_ENTRIES-1:0]   match_vec,
   output lmlt_pkg::match_status_type status
);
   import lmlt_pkg::*;

   logic [TABLE_ENTRIES-1:0] sat_vec;

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_vec[i] = (counts[i] != '0) && (addrs[i] == mac);
         sat_vec[i]   = match_vec[i] && (counts[i] == COUNT_MAX);
      end
      status.hit       = |match_vec;
      status.saturated = |sat_vec;
   end

endmodule

// File: design/lmlt_victim.sv
`timescale 1ns / 1ps

module lmlt_victim #(
   parameter int TABLE_ENTRIES = 8,
   parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  lmlt_pkg::count_type counts [TABLE_ENTRIES],
   output logic [IDX_W-1:0]    victim
);
   import lmlt_pkg::*;

   localparam int LEAVES = 1 << $clog2(TABLE_ENTRIES);
   localparam int NODES  = 2 * LEAVES - 1;

   count_type        node_cnt [NODES];
   logic [IDX_W-1:0] node_idx [NODES];

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         node_cnt[LEAVES-1+i] = (i < TABLE_ENTRIES) ? counts[i] : COUNT_MAX;
         node_idx[LEAVES-1+i] = IDX_W'(i);
      end
      for (int n = LEAVES - 2; n >= 0; n--) begin
         if (node_cnt[2*n+2] < node_cnt[2*n+1]) begin
            node_cnt[n] = node_cnt[2*n+2];
            node_idx[n] = node_idx[2*n+2];
         end else begin
            node_cnt[n] = node_cnt[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end
      end
      victim = node_idx[0];
   end

endmodule

// File: design/lfu_mac_learning_table.sv
`timescale 1ns / 1ps

// LFU MAC learning table.
// Requests arrive on req_bus (func, mac); each request yields one response
// on rsp_bus carrying hit. func learn counts a present address up (or halves
// every counter when it is already at its maximum) and on a miss replaces the
// least used entry; func lookup leaves the table unchanged.
// An accepted request waits in the s1 register, then its hit goes to the
// response register; match, victim pick and table update run as it advances.
// Throughput: one request per cycle unless the receiver stalls; the table
// update in the match stage shows each request its predecessor's table.
// Reset clears every use counter, so the table starts empty; it is usable
// in the first cycle after reset drops.
// When the receiver stalls, the response register holds, the captured request
// waits in front of it, and req_bus.ready drops once both are occupied.
module lfu_mac_learning_table #(
   parameter int TABLE_ENTRIES = 8
) (
   input logic       clock,
   input logic       reset,
   lmlt_req_if.sink  req_bus,
   lmlt_rsp_if.source rsp_bus
);
   import lmlt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic             s1_valid_ff, s1_valid_in;
   func_type         s1_func_ff;
   mac_type          s1_mac_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   mac_type          addr_ff [TABLE_ENTRIES];
   count_type        count_ff [TABLE_ENTRIES];
   count_type        count_in [TABLE_ENTRIES];

   logic                     advance;
   logic                     learn;
   logic [TABLE_ENTRIES-1:0] match_vec;
   match_status_type         status;
   logic [IDX_W-1:0]         victim;

   lmlt_match #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_match (
      .mac       (s1_mac_ff),
      .addrs     (addr_ff),
      .counts    (count_ff),
      .match_vec (match_vec),
      .status    (status)
   );

   lmlt_victim #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_victim (
      .counts (count_ff),
      .victim (victim)
   );

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign learn         = advance && (s1_func_ff == FUNC_LEARN);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hit   = rsp_hit_ff;

   always_comb begin
      s1_valid_in  = (req_bus.valid && req_bus.ready) || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         count_in[i] = count_ff[i];
         if (learn) begin
            if (status.hit) begin
               if (status.saturated) begin
                  count_in[i] = count_ff[i] >> 1;
               end else if (match_vec[i]) begin
                  count_in[i] = count_ff[i] + COUNT_FIRST;
               end
            end else if (victim == IDX_W'(i)) begin
               count_in[i] = COUNT_FIRST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_func_ff <= req_bus.func;
         s1_mac_ff  <= req_bus.mac;
      end
      if (advance) begin
         rsp_hit_ff <= status.hit;
      end
      if (learn && !status.hit) begin
         addr_ff[victim] <= s1_mac_ff;
      end
   end

endmodule

// File: design/lmlt_checker.sv
`timescale 1ns / 1ps

module lmlt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_backpressure_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled while response side is free");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready, 2))
      else $error("response without an accepted request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit)))
      else $error("stalled response changed");

endmodule

bind lfu_mac_learning_table lmlt_checker u_lmlt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_hit   (rsp_bus.hit)
);
